>>> design/voxel_chunk_stream_parser_assert.svh
// ---------------------------------------------------------------------------
// Voxel chunk stream parser assertion macros
// Concurrent checks for simulation; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef VOXEL_CHUNK_STREAM_PARSER_ASSERT_SVH
`define VOXEL_CHUNK_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset.
`define VCSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define VCSP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `VCSP_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define VCSP_ASSERT(lbl, clk, rst_n, prop)
`define VCSP_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> design/vcsp_pkg.sv
// ---------------------------------------------------------------------------
// vcsp_pkg
// Shared types and constants of the voxel chunk stream parser.
// ---------------------------------------------------------------------------
package vcsp_pkg;

    localparam int VCSP_MAX_DIM   = 256;
    localparam int VCSP_JOB_DEPTH = 4;
    localparam int VCSP_OUT_DEPTH = 4;

    localparam logic [31:0] TAG_SIZE = 32'h455A_4953;
    localparam logic [31:0] TAG_XYZI = 32'h495A_5958;

    localparam logic KIND_VOXEL = 1'b0;
    localparam logic KIND_SIZE  = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TAG,
        PH_CLEN,
        PH_CHILD,
        PH_SIZE,
        PH_COUNT,
        PH_VOXEL,
        PH_SKIP
    } t_phase;

    // Work handed from the parser to the address unit.
    typedef struct packed {
        logic       kind;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        logic [7:0] color;
        logic [8:0] dx;
        logic [8:0] dy;
        logic [8:0] dz;
    } t_job;

    // One finished result item.
    typedef struct packed {
        logic        kind;
        logic [23:0] address;
        logic [7:0]  color;
        logic        in_range;
        logic [8:0]  sx;
        logic [8:0]  sy;
        logic [8:0]  sz;
    } t_result;

endpackage

>>> design/vcsp_fifo.sv
// ---------------------------------------------------------------------------
// vcsp_fifo
// Small register FIFO with occupancy count, used for the job and result queues.
// ---------------------------------------------------------------------------
`include "voxel_chunk_stream_parser_assert.svh"

module vcsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rd_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd, r_wr;
    logic [CW-1:0]    r_count;
    logic             w_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;
    assign o_rd_data = r_mem[r_rd];
    assign w_pop     = i_pop & ~o_empty;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p == PW'(DEPTH - 1)) q = '0;
        else                     q = p + 1'b1;
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= wrap_inc(r_wr);
            if (w_pop)  r_rd <= wrap_inc(r_rd);
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

    `VCSP_ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, i_push && o_full)

endmodule

>>> design/vcsp_front.sv
// ---------------------------------------------------------------------------
// vcsp_front
// Byte-wise chunk parser: tracks the chunk phase and emits size and voxel jobs.
// ---------------------------------------------------------------------------
`include "voxel_chunk_stream_parser_assert.svh"

module vcsp_front #(
    parameter int MAX_DIM = vcsp_pkg::VCSP_MAX_DIM
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_data_byte,
    input  logic           i_file_start,
    output logic           o_full,
    output logic           o_job_push,
    output vcsp_pkg::t_job o_job,
    input  logic           i_job_full
);

    import vcsp_pkg::*;

    t_phase      r_phase, n_phase, c_phase;
    logic [2:0]  r_pos, n_pos, c_pos;
    logic [31:0] r_shift, n_shift, c_shift;
    logic [31:0] r_tag, n_tag, c_tag;
    logic [31:0] r_clen, n_clen, c_clen;
    logic [30:0] r_skip, n_skip, c_skip;
    logic [30:0] r_vox, n_vox, c_vox;
    logic [8:0]  r_dx, n_dx, c_dx;
    logic [8:0]  r_dy, n_dy, c_dy;
    logic [8:0]  r_dz, n_dz, c_dz;
    logic [1:0]  r_sfi, n_sfi, c_sfi;
    logic [7:0]  r_hx, n_hx, c_hx;
    logic [7:0]  r_hz, n_hz, c_hz;
    logic [7:0]  r_hy, n_hy, c_hy;

    logic        w_take;
    logic [31:0] w_word;
    logic        w_word_done;
    logic        w_emit;

    function automatic logic [8:0] clamp_dim(input logic [31:0] w);
        logic [8:0] r;
        if (w[31])                    r = '0;
        else if (w > 32'(MAX_DIM))    r = 9'(MAX_DIM);
        else                          r = w[8:0];
        return r;
    endfunction

    function automatic logic [30:0] non_negative(input logic [31:0] w);
        return w[31] ? 31'd0 : w[30:0];
    endfunction

    assign o_full = i_job_full;
    assign w_take = i_push & ~i_job_full;

    // A new file starts from the cleared state before its first byte.
    assign c_phase = i_file_start ? PH_HEADER : r_phase;
    assign c_pos   = i_file_start ? '0 : r_pos;
    assign c_shift = i_file_start ? '0 : r_shift;
    assign c_tag   = i_file_start ? '0 : r_tag;
    assign c_clen  = i_file_start ? '0 : r_clen;
    assign c_skip  = i_file_start ? '0 : r_skip;
    assign c_vox   = i_file_start ? '0 : r_vox;
    assign c_dx    = i_file_start ? '0 : r_dx;
    assign c_dy    = i_file_start ? '0 : r_dy;
    assign c_dz    = i_file_start ? '0 : r_dz;
    assign c_sfi   = i_file_start ? '0 : r_sfi;
    assign c_hx    = i_file_start ? '0 : r_hx;
    assign c_hz    = i_file_start ? '0 : r_hz;
    assign c_hy    = i_file_start ? '0 : r_hy;

    assign w_word      = {i_data_byte, c_shift[31:8]};
    assign w_word_done = (c_pos == 3'd3);

    // Next phase.
    always_comb begin
        n_phase = c_phase;
        case (c_phase)
            PH_HEADER: begin
                if (c_pos == 3'd7) n_phase = PH_TAG;
            end
            PH_SKIP: begin
                if (c_skip == 31'd1) n_phase = PH_TAG;
            end
            PH_VOXEL: begin
                if (c_pos[1:0] == 2'd3 && c_vox == 31'd1) n_phase = PH_TAG;
            end
            PH_TAG: begin
                if (w_word_done) n_phase = PH_CLEN;
            end
            PH_CLEN: begin
                if (w_word_done) n_phase = PH_CHILD;
            end
            PH_CHILD: begin
                if (w_word_done) begin
                    if (c_tag == TAG_SIZE)               n_phase = PH_SIZE;
                    else if (c_tag == TAG_XYZI)          n_phase = PH_COUNT;
                    else if (non_negative(c_clen) == '0) n_phase = PH_TAG;
                    else                                 n_phase = PH_SKIP;
                end
            end
            PH_SIZE: begin
                if (w_word_done && c_sfi != 2'd0 && c_sfi != 2'd1) n_phase = PH_TAG;
            end
            PH_COUNT: begin
                if (w_word_done) begin
                    n_phase = (non_negative(w_word) == '0) ? PH_TAG : PH_VOXEL;
                end
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
    end

    // Datapath and job outputs.
    always_comb begin
        n_pos   = c_pos;
        n_shift = c_shift;
        n_tag   = c_tag;
        n_clen  = c_clen;
        n_skip  = c_skip;
        n_vox   = c_vox;
        n_dx    = c_dx;
        n_dy    = c_dy;
        n_dz    = c_dz;
        n_sfi   = c_sfi;
        n_hx    = c_hx;
        n_hz    = c_hz;
        n_hy    = c_hy;
        w_emit  = 1'b0;
        o_job   = '0;
        case (c_phase)
            PH_HEADER: begin
                n_pos = (c_pos == 3'd7) ? 3'd0 : c_pos + 3'd1;
            end
            PH_SKIP: begin
                n_skip = c_skip - 31'd1;
            end
            PH_VOXEL: begin
                case (c_pos[1:0])
                    2'd0: begin
                        n_hx  = i_data_byte;
                        n_pos = 3'd1;
                    end
                    2'd1: begin
                        n_hz  = i_data_byte;
                        n_pos = 3'd2;
                    end
                    2'd2: begin
                        n_hy  = i_data_byte;
                        n_pos = 3'd3;
                    end
                    default: begin
                        n_pos       = 3'd0;
                        n_vox       = c_vox - 31'd1;
                        w_emit      = 1'b1;
                        o_job.kind  = KIND_VOXEL;
                        o_job.x     = c_hx;
                        o_job.y     = c_hy;
                        o_job.z     = c_hz;
                        o_job.color = i_data_byte;
                        o_job.dx    = c_dx;
                        o_job.dy    = c_dy;
                        o_job.dz    = c_dz;
                    end
                endcase
            end
            default: begin
                // Assemble a little-endian word, one byte a step.
                n_shift = w_word;
                if (!w_word_done) begin
                    n_pos = c_pos + 3'd1;
                end else begin
                    n_pos = 3'd0;
                    case (c_phase)
                        PH_CLEN: begin
                            n_clen = w_word;
                        end
                        PH_CHILD: begin
                            if (c_tag == TAG_SIZE) begin
                                n_sfi = 2'd0;
                            end else if (c_tag != TAG_XYZI
                                         && non_negative(c_clen) != '0) begin
                                n_skip = non_negative(c_clen);
                            end
                        end
                        PH_SIZE: begin
                            if (c_sfi == 2'd0) begin
                                n_dx  = clamp_dim(w_word);
                                n_sfi = 2'd1;
                            end else if (c_sfi == 2'd1) begin
                                n_dz  = clamp_dim(w_word);
                                n_sfi = 2'd2;
                            end else begin
                                n_dy       = clamp_dim(w_word);
                                n_sfi      = 2'd0;
                                w_emit     = 1'b1;
                                o_job.kind = KIND_SIZE;
                                o_job.dx   = c_dx;
                                o_job.dy   = clamp_dim(w_word);
                                o_job.dz   = c_dz;
                            end
                        end
                        PH_COUNT: begin
                            if (non_negative(w_word) != '0) n_vox = non_negative(w_word);
                        end
                        default: begin
                            n_tag = w_word;
                        end
                    endcase
                end
            end
        endcase
    end

    assign o_job_push = w_take & w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_shift <= '0;
            r_tag   <= '0;
            r_clen  <= '0;
            r_skip  <= '0;
            r_vox   <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_dz    <= '0;
            r_sfi   <= '0;
            r_hx    <= '0;
            r_hz    <= '0;
            r_hy    <= '0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_tag   <= n_tag;
            r_clen  <= n_clen;
            r_skip  <= n_skip;
            r_vox   <= n_vox;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_dz    <= n_dz;
            r_sfi   <= n_sfi;
            r_hx    <= n_hx;
            r_hz    <= n_hz;
            r_hy    <= n_hy;
        end
    end

    `VCSP_ASSERT(a_voxel_count_live, i_clk, i_rst_n, (r_phase == PH_VOXEL) |-> (r_vox != '0))
    `VCSP_ASSERT(a_skip_count_live, i_clk, i_rst_n, (r_phase == PH_SKIP) |-> (r_skip != '0))

endmodule

>>> design/vcsp_back.sv
// ---------------------------------------------------------------------------
// vcsp_back
// Address unit: two multiply stages form x + y*sx + z*sx*sy for each job.
// ---------------------------------------------------------------------------
`include "voxel_chunk_stream_parser_assert.svh"

module vcsp_back #(
    parameter int OUT_DEPTH = vcsp_pkg::VCSP_OUT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_empty,
    input  vcsp_pkg::t_job                 i_job,
    output logic                           o_job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_out_push,
    output vcsp_pkg::t_result              o_result
);

    import vcsp_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic [CW:0]  w_used;
    logic         w_issue;

    logic         r_v1, r_k1, r_ok1;
    logic [7:0]   r_x1, r_z1, r_c1;
    logic [8:0]   r_dx1, r_dy1, r_dz1;
    logic [16:0]  r_ydx1, r_dxdy1;

    logic         r_v2, r_k2, r_ok2;
    logic [7:0]   r_c2;
    logic [8:0]   r_dx2, r_dy2, r_dz2;
    logic [16:0]  r_part2;
    logic [23:0]  r_zp2;

    // Issue only when the result queue has room for everything in flight.
    assign w_used  = {1'b0, i_out_count} + (CW+1)'(r_v1) + (CW+1)'(r_v2);
    assign w_issue = ~i_job_empty && (w_used < (CW+1)'(OUT_DEPTH));
    assign o_job_pop = w_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k1    <= i_job.kind;
        r_ok1   <= (i_job.kind == KIND_VOXEL)
                   && ({1'b0, i_job.x} < i_job.dx)
                   && ({1'b0, i_job.y} < i_job.dy)
                   && ({1'b0, i_job.z} < i_job.dz);
        r_x1    <= i_job.x;
        r_z1    <= i_job.z;
        r_c1    <= i_job.color;
        r_dx1   <= i_job.dx;
        r_dy1   <= i_job.dy;
        r_dz1   <= i_job.dz;
        r_ydx1  <= 17'(i_job.y) * 17'(i_job.dx);
        r_dxdy1 <= 17'(i_job.dx) * 17'(i_job.dy);

        r_k2    <= r_k1;
        r_ok2   <= r_ok1;
        r_c2    <= r_c1;
        r_dx2   <= r_dx1;
        r_dy2   <= r_dy1;
        r_dz2   <= r_dz1;
        r_part2 <= 17'(r_x1) + r_ydx1;
        r_zp2   <= 24'(r_z1) * 24'(r_dxdy1);
    end

    assign o_out_push        = r_v2;
    assign o_result.kind     = r_k2;
    assign o_result.address  = r_zp2 + 24'(r_part2);
    assign o_result.color    = r_c2;
    assign o_result.in_range = r_ok2;
    assign o_result.sx       = r_dx2;
    assign o_result.sy       = r_dy2;
    assign o_result.sz       = r_dz2;

    `VCSP_ASSERT(a_credit_bound, i_clk, i_rst_n, w_used <= (CW+1)'(OUT_DEPTH))
    `VCSP_ASSERT(a_room_on_push, i_clk, i_rst_n, r_v2 |-> (i_out_count < CW'(OUT_DEPTH)))

endmodule

>>> design/voxel_chunk_stream_parser.sv
// ---------------------------------------------------------------------------
// voxel_chunk_stream_parser
// Byte-stream parser for voxel model files, emitting size and voxel writes.
// ---------------------------------------------------------------------------
// The block takes one file byte per cycle on the push side while full is
// low, and it keeps taking bytes while results wait: full rises only
// while the job queue between the parser and the address unit is occupied
// to its depth. A byte that completes a SIZE chunk or an XYZI record shows
// up as a result once it has passed the job queue, the two multiply stages
// of the address unit and the result queue, later only while the address
// unit waits for room in the result queue. Raise file_start with the first
// byte of a file to restart the parser and clear the dimensions. Voxel
// results carry x + y*size_x + z*size_x*size_y with in_range low when any
// coordinate lies outside the dimensions; size results carry zero address,
// color and range.
// ---------------------------------------------------------------------------

module voxel_chunk_stream_parser #(
    parameter int MAX_DIM   = vcsp_pkg::VCSP_MAX_DIM,   // 4 .. 256
    parameter int JOB_DEPTH = vcsp_pkg::VCSP_JOB_DEPTH, // 1 or more
    parameter int OUT_DEPTH = vcsp_pkg::VCSP_OUT_DEPTH  // 3 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [23:0] o_voxel_address,
    output logic [7:0]  o_color_index,
    output logic        o_in_range,
    output logic [8:0]  o_size_x,
    output logic [8:0]  o_size_y,
    output logic [8:0]  o_size_z
);

    import vcsp_pkg::*;

    localparam int OCW = $clog2(OUT_DEPTH + 1);

    // Front to job queue.
    t_job           w_job_in;
    logic           w_job_push;
    logic           w_job_full;

    // Job queue to back.
    t_job           w_job_out;
    logic           w_job_empty;
    logic           w_job_pop;

    // Back to result queue.
    t_result        w_res_in;
    t_result        w_res_out;
    logic           w_res_push;
    logic [OCW-1:0] w_res_count;

    // Parse bytes and classify them into jobs.
    vcsp_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_full       (full),
        .o_job_push   (w_job_push),
        .o_job        (w_job_in),
        .i_job_full   (w_job_full)
    );

    // Decouple the parser from the address unit.
    vcsp_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_job_push),
        .i_wr_data (w_job_in),
        .i_pop     (w_job_pop),
        .o_rd_data (w_job_out),
        .o_empty   (w_job_empty),
        .o_full    (w_job_full),
        .o_count   ()
    );

    // Form the linear address behind the parser.
    vcsp_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_out_count (w_res_count),
        .o_out_push  (w_res_push),
        .o_result    (w_res_in)
    );

    // Hold finished results until the consumer pops them.
    vcsp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_res_push),
        .i_wr_data (w_res_in),
        .i_pop     (pop),
        .o_rd_data (w_res_out),
        .o_empty   (empty),
        .o_full    (),
        .o_count   (w_res_count)
    );

    assign o_result_kind   = w_res_out.kind;
    assign o_voxel_address = w_res_out.address;
    assign o_color_index   = w_res_out.color;
    assign o_in_range      = w_res_out.in_range;
    assign o_size_x        = w_res_out.sx;
    assign o_size_y        = w_res_out.sy;
    assign o_size_z        = w_res_out.sz;

endmodule

>>> bench/voxel_chunk_stream_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// voxel_chunk_stream_checker
// Watches the byte and result queues of the parser, predicts the result of
// every accepted byte and compares each popped result field by field.
// ---------------------------------------------------------------------------

module voxel_chunk_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_result_kind,
    input  logic [23:0] i_voxel_address,
    input  logic [7:0]  i_color_index,
    input  logic        i_in_range,
    input  logic [8:0]  i_size_x,
    input  logic [8:0]  i_size_y,
    input  logic [8:0]  i_size_z,
    output int          o_fail_count,
    output int          o_pending
);
    import vcsp_pkg::*;

    localparam int MAX_DIM = VCSP_MAX_DIM;

    // Parser state as seen from the byte stream
    t_phase      phase;
    logic [2:0]  pos;
    logic [31:0] shreg;
    logic [31:0] tag;
    logic [31:0] clen;
    logic [31:0] skip_left;
    logic [31:0] voxels_left;
    logic [8:0]  dim_x;
    logic [8:0]  dim_y;
    logic [8:0]  dim_z;
    logic [1:0]  size_idx;
    logic [7:0]  held_x;
    logic [7:0]  held_z;
    logic [7:0]  held_y;

    t_result     expected_results[$];
    int          fail_count = 0;

    function automatic logic [8:0] clamp_dim(input logic [31:0] w);
        if (w[31]) return 9'd0;
        if (w > MAX_DIM) return 9'(MAX_DIM);
        return w[8:0];
    endfunction

    function automatic logic [31:0] non_negative(input logic [31:0] w);
        return w[31] ? 32'd0 : w;
    endfunction

    task automatic restart_parser();
        phase       = PH_HEADER;
        pos         = '0;
        shreg       = '0;
        tag         = '0;
        clen        = '0;
        skip_left   = '0;
        voxels_left = '0;
        dim_x       = '0;
        dim_y       = '0;
        dim_z       = '0;
        size_idx    = '0;
        held_x      = '0;
        held_z      = '0;
        held_y      = '0;
    endtask

    task automatic queue_result(input logic kind, input logic [23:0] addr,
                                input logic [7:0] color, input logic ok);
        t_result r;
        r.kind     = kind;
        r.address  = addr;
        r.color    = color;
        r.in_range = ok;
        r.sx       = dim_x;
        r.sy       = dim_y;
        r.sz       = dim_z;
        expected_results.push_back(r);
    endtask

    // Advance the parser by one accepted byte.
    task automatic step_parser(input logic [7:0] b, input logic fs);
        logic [31:0] addr;
        if (fs) restart_parser();
        case (phase)
            PH_HEADER: begin
                if (pos >= 3'd7) begin
                    pos   = '0;
                    phase = PH_TAG;
                end else begin
                    pos = pos + 3'd1;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 32'd1;
                if (skip_left == '0) phase = PH_TAG;
            end
            PH_VOXEL: begin
                case (pos[1:0])
                    2'd0: begin held_x = b; pos = 3'd1; end
                    2'd1: begin held_z = b; pos = 3'd2; end
                    2'd2: begin held_y = b; pos = 3'd3; end
                    default: begin
                        pos  = '0;
                        addr = held_x + held_y * dim_x + held_z * dim_x * dim_y;
                        queue_result(KIND_VOXEL, addr[23:0], b,
                                     (held_x < dim_x) && (held_y < dim_y) && (held_z < dim_z));
                        voxels_left = voxels_left - 32'd1;
                        if (voxels_left == '0) phase = PH_TAG;
                    end
                endcase
            end
            default: begin
                // Assemble little-endian words
                shreg = {b, shreg[31:8]};
                if (pos < 3'd3) begin
                    pos = pos + 3'd1;
                end else begin
                    pos = '0;
                    case (phase)
                        PH_CLEN: begin
                            clen  = shreg;
                            phase = PH_CHILD;
                        end
                        PH_CHILD: begin
                            if (tag == TAG_SIZE) begin
                                size_idx = '0;
                                phase    = PH_SIZE;
                            end else if (tag == TAG_XYZI) begin
                                phase = PH_COUNT;
                            end else if (non_negative(clen) == '0) begin
                                phase = PH_TAG;
                            end else begin
                                skip_left = non_negative(clen);
                                phase     = PH_SKIP;
                            end
                        end
                        PH_SIZE: begin
                            case (size_idx)
                                2'd0: begin dim_x = clamp_dim(shreg); size_idx = 2'd1; end
                                2'd1: begin dim_z = clamp_dim(shreg); size_idx = 2'd2; end
                                default: begin
                                    dim_y    = clamp_dim(shreg);
                                    size_idx = '0;
                                    phase    = PH_TAG;
                                    queue_result(KIND_SIZE, '0, '0, 1'b0);
                                end
                            endcase
                        end
                        PH_COUNT: begin
                            if (non_negative(shreg) == '0) begin
                                phase = PH_TAG;
                            end else begin
                                voxels_left = non_negative(shreg);
                                phase       = PH_VOXEL;
                            end
                        end
                        default: begin
                            tag   = shreg;
                            phase = PH_CLEN;
                        end
                    endcase
                end
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d address %0d color %0d",
                   i_result_kind, i_voxel_address, i_color_index);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("result_kind", want.kind, i_result_kind);
            check_field("voxel_address", want.address, i_voxel_address);
            check_field("color_index", want.color, i_color_index);
            check_field("in_range", want.in_range, i_in_range);
            check_field("size_x", want.sx, i_size_x);
            check_field("size_y", want.sy, i_size_y);
            check_field("size_z", want.sz, i_size_z);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_parser();
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) check_result();
            if (i_push && !i_full) step_parser(i_data_byte, i_file_start);
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> bench/tb_voxel_chunk_stream_parser.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_voxel_chunk_stream_parser
// Feeds directed and random model files byte by byte into the parser under
// random idling and back-pressure; a checker beside the block scores results.
// ---------------------------------------------------------------------------

module tb_voxel_chunk_stream_parser;
    import vcsp_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_BYTES = 64;
    localparam int DENSE_VOXELS = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;     // job queue, two multiply stages, result queue
    localparam int LIMIT_NS     = 4_000_000;

    // Idling profile of both sides
    typedef enum logic [1:0] {
        PACE_RX_SLOW,   // sender idles rarely, receiver often
        PACE_TX_SLOW,   // sender idles often, receiver rarely
        PACE_FREE       // nobody idles
    } t_pace;

    // One byte request of the input queue
    typedef struct packed {
        logic [7:0] data;
        logic       starts_file;
    } t_request;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        push       = 1'b0;
    logic [7:0]  data_byte  = 8'd0;
    logic        file_start = 1'b0;
    logic        pop        = 1'b0;
    logic        full;
    logic        empty;
    logic        result_kind;
    logic [23:0] voxel_address;
    logic [7:0]  color_index;
    logic        in_range;
    logic [8:0]  size_x;
    logic [8:0]  size_y;
    logic [8:0]  size_z;
    int          fail_count;
    int          pending;

    t_request    file_bytes[$];
    t_pace       pace = PACE_RX_SLOW;
    int          tx_slow_from;
    int          free_from;

    // Dimensions as the stream announces them, used to aim coordinates
    logic [8:0]  gen_dx;
    logic [8:0]  gen_dy;
    logic [8:0]  gen_dz;

    always #(CLK_HALF) i_clk = ~i_clk;

    voxel_chunk_stream_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (data_byte),
        .i_file_start    (file_start),
        .empty           (empty),
        .pop             (pop),
        .o_result_kind   (result_kind),
        .o_voxel_address (voxel_address),
        .o_color_index   (color_index),
        .o_in_range      (in_range),
        .o_size_x        (size_x),
        .o_size_y        (size_y),
        .o_size_z        (size_z)
    );

    voxel_chunk_stream_checker u_result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_data_byte     (data_byte),
        .i_file_start    (file_start),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_result_kind   (result_kind),
        .i_voxel_address (voxel_address),
        .i_color_index   (color_index),
        .i_in_range      (in_range),
        .i_size_x        (size_x),
        .i_size_y        (size_y),
        .i_size_z        (size_z),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // -----------------------------------------------------------------------
    // Stream building
    // -----------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] d, input logic starts);
        file_bytes.push_back({d, starts});
    endtask

    // Append a 32-bit word, low byte first.
    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8], 1'b0);
    endtask

    // Open a new file; a header shorter than 8 bytes makes a broken file.
    task automatic start_file(input int header_len);
        put_byte(8'($urandom), 1'b1);
        repeat (header_len - 1) put_byte(8'($urandom), 1'b0);
        gen_dx = '0;
        gen_dy = '0;
        gen_dz = '0;
    endtask

    // Tag, content length and an ignored children length.
    task automatic put_chunk_head(input logic [31:0] tag, input logic [31:0] clen);
        put_word(tag);
        put_word(clen);
        put_word($urandom);
    endtask

    function automatic logic [8:0] announced_dim(input logic [31:0] w);
        if (w[31]) return 9'd0;
        if (w > VCSP_MAX_DIM) return 9'(VCSP_MAX_DIM);
        return w[8:0];
    endfunction

    // SIZE values arrive as x, z, y; the content length is never used.
    task automatic put_size(input logic [31:0] x, input logic [31:0] z,
                            input logic [31:0] y);
        put_chunk_head(TAG_SIZE, $urandom_range(0, 1) ? 32'd12 : $urandom);
        put_word(x);
        put_word(z);
        put_word(y);
        gen_dx = announced_dim(x);
        gen_dz = announced_dim(z);
        gen_dy = announced_dim(y);
    endtask

    task automatic put_xyzi(input logic [31:0] count);
        put_chunk_head(TAG_XYZI, $urandom);
        put_word(count);
    endtask

    task automatic put_record(input logic [7:0] x, input logic [7:0] z,
                              input logic [7:0] y, input logic [7:0] color);
        put_byte(x, 1'b0);
        put_byte(z, 1'b0);
        put_byte(y, 1'b0);
        put_byte(color, 1'b0);
    endtask

    // Mostly inside the announced dimension, sometimes anywhere.
    function automatic logic [7:0] pick_coord(input logic [8:0] dim);
        logic [7:0] c;
        if (dim != 0 && $urandom_range(0, 9) < 8) c = 8'($urandom_range(0, dim - 1));
        else c = 8'($urandom);
        return c;
    endfunction

    task automatic put_random_records(input int n);
        repeat (n) put_record(pick_coord(gen_dx), pick_coord(gen_dz),
                              pick_coord(gen_dy), 8'($urandom));
    endtask

    // Any other chunk: skipped by its content length.
    task automatic put_skipped(input logic [31:0] clen, input int n_content);
        logic [31:0] tag;
        tag = $urandom;
        if (tag == TAG_SIZE || tag == TAG_XYZI) tag = ~tag;
        put_chunk_head(tag, clen);
        repeat (n_content) put_byte(8'($urandom), 1'b0);
    endtask

    // Mostly small dimensions, with the clamping corners now and then.
    function automatic logic [31:0] random_dim();
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1:       return 32'd256;
            2:       return $urandom_range(257, 1000);
            3:       return 32'h8000_0000 | $urandom;
            4:       return $urandom;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic add_random_file();
        int n;
        if ($urandom_range(0, 14) == 0) begin
            start_file($urandom_range(1, 7));
            return;
        end
        start_file(8);
        if ($urandom_range(0, 4) != 0) put_size(random_dim(), random_dim(), random_dim());
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1: put_size(random_dim(), random_dim(), random_dim());
                2, 3, 4, 5, 6: begin
                    n = $urandom_range(1, 10);
                    put_xyzi(n);
                    put_random_records(n);
                end
                7: begin
                    n = $urandom_range(1, 6);
                    put_skipped(n, n);
                end
                8:       put_xyzi($urandom_range(0, 1) ? 32'd0 : (32'h8000_0000 | $urandom));
                default: put_skipped($urandom_range(0, 1) ? 32'd0
                                                          : (32'h8000_0000 | $urandom), 0);
            endcase
        end
        // Trail some garbage now and then; the next file start recovers
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom), 1'b0);
    endtask

    // -----------------------------------------------------------------------
    // Sender: build the stream, release reset, offer one request per byte
    // -----------------------------------------------------------------------
    initial begin : sender
        int gap_pct;

        // Voxels before any SIZE: dimensions are zero, all flagged
        start_file(8);
        put_xyzi(2);
        put_record(8'd0, 8'd0, 8'd0, 8'd1);
        put_record(8'd255, 8'd255, 8'd255, 8'd254);
        // Clamp above the limit and a negative value to zero
        put_size(32'd300, 32'h8000_0000, 32'd256);
        put_xyzi(1);
        put_random_records(1);
        // Inside, x outside, z outside, y outside
        put_size(32'd4, 32'd4, 32'd4);
        put_xyzi(4);
        put_record(8'd3, 8'd3, 8'd3, 8'h55);
        put_record(8'd4, 8'd0, 8'd0, 8'hAA);
        put_record(8'd0, 8'd4, 8'd0, 8'h0F);
        put_record(8'd0, 8'd0, 8'd4, 8'hF0);
        // Negative and zero counts go straight to the next tag
        put_xyzi(32'hFFFF_FFFF);
        put_xyzi(32'd0);
        // Other chunks: short, negative and zero lengths
        put_skipped(32'd3, 3);
        put_skipped(32'h8000_0001, 0);
        put_skipped(32'd0, 0);
        // Full dimensions and the top address
        put_size(32'd256, 32'd256, 32'd256);
        put_xyzi(1);
        put_record(8'd255, 8'd255, 8'd255, 8'd255);
        put_size(32'd0, 32'd0, 32'd0);
        // Restart in the middle of a chunk
        put_chunk_head(TAG_SIZE, 32'd12);
        put_byte(8'h12, 1'b0);
        put_byte(8'h34, 1'b0);
        start_file(8);
        put_size(32'd2, 32'd3, 32'd5);
        put_xyzi(2);
        put_random_records(2);

        // Random files while the sender idles often
        tx_slow_from = file_bytes.size();
        while (file_bytes.size() - tx_slow_from < RANDOM_BYTES) add_random_file();
        free_from = file_bytes.size();
        // Open the free-running stretch with a dense voxel run so the block
        // fills up while the receiver holds off
        start_file(8);
        put_size(32'd16, 32'd16, 32'd16);
        put_xyzi(DENSE_VOXELS);
        put_random_records(DENSE_VOXELS);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int idx = 0; idx < file_bytes.size(); idx++) begin
            if (idx == tx_slow_from) pace = PACE_TX_SLOW;
            else if (idx == free_from) pace = PACE_FREE;
            gap_pct = (pace == PACE_RX_SLOW) ? 12 : (pace == PACE_TX_SLOW) ? 73 : 0;
            // Idle before the request, then hold it until accepted
            while ($urandom_range(0, 99) < gap_pct) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
            push <= 1'b1;
            {data_byte, file_start} <= file_bytes[idx];
            @(posedge i_clk);
            while (full) @(posedge i_clk);
        end
        push <= 1'b0;

        // Drain every expected result, then watch for stray ones
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // -----------------------------------------------------------------------
    // Receiver: pop at random; hold off once for a long stretch when the
    // free-running profile begins, so the input side stalls
    // -----------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pace == PACE_FREE && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >=
                        ((pace == PACE_RX_SLOW) ? 73 : (pace == PACE_TX_SLOW) ? 12 : 0));
            end
        end
    end

    // Drop the run if it hangs
    initial begin : watchdog
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/vcsp_pkg.sv
design/vcsp_fifo.sv
design/vcsp_front.sv
design/vcsp_back.sv
design/voxel_chunk_stream_parser.sv
bench/voxel_chunk_stream_checker.sv
bench/tb_voxel_chunk_stream_parser.sv
